// ===== hdl/csp_pkg.sv =====
package csp_pkg;

   localparam int KEY_MAX = 31;
   localparam logic [32:0] NUM_SAT = 33'h080000000;

   typedef enum logic [1:0] {
      PH_SKIP  = 2'd0,
      PH_KEY   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_KEY   = 4'd1;
   localparam logic [3:0] ST_ALIGN     = 4'd2;
   localparam logic [3:0] ST_LINE      = 4'd4;
   localparam logic [3:0] ST_POSITION  = 4'd6;
   localparam logic [3:0] ST_SIZE      = 4'd8;
   localparam logic [3:0] ST_VERTICAL  = 4'd10;

   localparam int NF_BAD = 0;
   localparam int NF_DIGIT = 1;
   localparam int NF_MINUS_LATE = 2;
   localparam int NF_PCT = 3;
   localparam int NF_PCT_LATE = 4;
   localparam int NF_MINUS_FIRST = 5;

   typedef struct packed {
      logic [2:0]  align;
      logic [31:0] line_raw;
      logic        line_auto;
      logic        snap;
      logic [6:0]  position;
      logic [6:0]  size;
      logic [1:0]  vertical;
   } settings_type;

   localparam settings_type SETTINGS_DEFAULT = '{
      align: 3'd1, line_raw: 32'd0, line_auto: 1'b1, snap: 1'b1,
      position: 7'd50, size: 7'd100, vertical: 2'd0};

   typedef struct packed {
      phase_type   phase;
      logic [5:0]  key_length;
      logic [4:0]  key_match;
      logic [5:0]  value_length;
      logic [6:0]  word_match;
      logic [5:0]  flags;
      logic [32:0] accum;
   } word_type;

   localparam word_type WORD_CLEAR = '{
      phase: PH_SKIP, key_length: 6'd0, key_match: 5'h1f, value_length: 6'd0,
      word_match: 7'h7f, flags: 6'd0, accum: 33'd0};

   function automatic logic [7:0] key_char(input int k, input logic [5:0] i);
      logic [7:0] r;
      r = 8'h00;
      unique case (k)
         0: unique case (i)
               6'd0: r = "a"; 6'd1: r = "l"; 6'd2: r = "i"; 6'd3: r = "g"; 6'd4: r = "n";
               default: r = 8'h00;
            endcase
         1: unique case (i)
               6'd0: r = "l"; 6'd1: r = "i"; 6'd2: r = "n"; 6'd3: r = "e";
               default: r = 8'h00;
            endcase
         2: unique case (i)
               6'd0: r = "p"; 6'd1: r = "o"; 6'd2: r = "s"; 6'd3: r = "i";
               6'd4: r = "t"; 6'd5: r = "i"; 6'd6: r = "o"; 6'd7: r = "n";
               default: r = 8'h00;
            endcase
         3: unique case (i)
               6'd0: r = "s"; 6'd1: r = "i"; 6'd2: r = "z"; 6'd3: r = "e";
               default: r = 8'h00;
            endcase
         default: unique case (i)
               6'd0: r = "v"; 6'd1: r = "e"; 6'd2: r = "r"; 6'd3: r = "t";
               6'd4: r = "i"; 6'd5: r = "c"; 6'd6: r = "a"; 6'd7: r = "l";
               default: r = 8'h00;
            endcase
      endcase
      return r;
   endfunction

   function automatic logic [5:0] key_len(input int k);
      logic [5:0] r;
      unique case (k)
         0: r = 6'd5;
         1: r = 6'd4;
         2: r = 6'd8;
         3: r = 6'd4;
         default: r = 6'd8;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] kw_char(input int k, input logic [5:0] i);
      logic [7:0] r;
      r = 8'h00;
      unique case (k)
         0: unique case (i)
               6'd0: r = "s"; 6'd1: r = "t"; 6'd2: r = "a"; 6'd3: r = "r"; 6'd4: r = "t";
               default: r = 8'h00;
            endcase
         1: unique case (i)
               6'd0: r = "m"; 6'd1: r = "i"; 6'd2: r = "d"; 6'd3: r = "d";
               6'd4: r = "l"; 6'd5: r = "e";
               default: r = 8'h00;
            endcase
         2: unique case (i)
               6'd0: r = "e"; 6'd1: r = "n"; 6'd2: r = "d";
               default: r = 8'h00;
            endcase
         3: unique case (i)
               6'd0: r = "l"; 6'd1: r = "e"; 6'd2: r = "f"; 6'd3: r = "t";
               default: r = 8'h00;
            endcase
         4: unique case (i)
               6'd0: r = "r"; 6'd1: r = "i"; 6'd2: r = "g"; 6'd3: r = "h"; 6'd4: r = "t";
               default: r = 8'h00;
            endcase
         5: unique case (i)
               6'd0: r = "l"; 6'd1: r = "r";
               default: r = 8'h00;
            endcase
         default: unique case (i)
               6'd0: r = "r"; 6'd1: r = "l";
               default: r = 8'h00;
            endcase
      endcase
      return r;
   endfunction

   function automatic logic [5:0] kw_len(input int k);
      logic [5:0] r;
      unique case (k)
         0: r = 6'd5;
         1: r = 6'd6;
         2: r = 6'd3;
         3: r = 6'd4;
         4: r = 6'd5;
         default: r = 6'd2;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/csp_scan.sv =====
module csp_scan (
   input  csp_pkg::word_type word_cur,
   input  logic [7:0]        char_byte,
   output csp_pkg::word_type word_nxt
);
   import csp_pkg::*;

   logic [36:0] times_ten;
   logic [36:0] accum_sum;

   always_comb begin
      word_nxt = word_cur;
      times_ten = '0;
      accum_sum = '0;
      if (word_cur.phase != PH_VALUE) begin
         word_nxt.phase = PH_KEY;
         if (char_byte == ":") begin
            for (int k = 0; k < 5; k++) begin
               if (key_len(k) != word_cur.key_length) word_nxt.key_match[k] = 1'b0;
            end
            word_nxt.phase = PH_VALUE;
         end else begin
            for (int k = 0; k < 5; k++) begin
               if (word_cur.key_length >= key_len(k) ||
                   key_char(k, word_cur.key_length) != char_byte)
                  word_nxt.key_match[k] = 1'b0;
            end
            if (word_cur.key_length != 6'd63) word_nxt.key_length = word_cur.key_length + 6'd1;
         end
      end else begin
         for (int k = 0; k < 7; k++) begin
            if (word_cur.value_length >= kw_len(k) ||
                kw_char(k, word_cur.value_length) != char_byte)
               word_nxt.word_match[k] = 1'b0;
         end
         if (word_cur.flags[NF_PCT]) word_nxt.flags[NF_PCT_LATE] = 1'b1;
         if (char_byte >= "0" && char_byte <= "9") begin
            word_nxt.flags[NF_DIGIT] = 1'b1;
            times_ten = {word_cur.accum, 3'b000} + {2'b00, word_cur.accum, 1'b0};
            accum_sum = times_ten + {33'd0, char_byte[3:0]};
            word_nxt.accum = (accum_sum > {4'd0, NUM_SAT}) ? NUM_SAT : accum_sum[32:0];
         end else if (char_byte == "-") begin
            if (word_cur.value_length == 6'd0) word_nxt.flags[NF_MINUS_FIRST] = 1'b1;
            else word_nxt.flags[NF_MINUS_LATE] = 1'b1;
         end else if (char_byte == "%") begin
            word_nxt.flags[NF_PCT] = 1'b1;
         end else begin
            word_nxt.flags[NF_BAD] = 1'b1;
         end
         if (word_cur.value_length != 6'd63) word_nxt.value_length = word_cur.value_length + 6'd1;
      end
   end

endmodule

// ===== hdl/csp_judge.sv =====
module csp_judge (
   input  csp_pkg::word_type     word_fin,
   input  csp_pkg::settings_type set_cur,
   input  logic [4:0]            have_cur,
   output csp_pkg::settings_type set_nxt,
   output logic [4:0]            have_nxt,
   output logic [3:0]            status
);
   import csp_pkg::*;

   logic [5:0]  f;
   logic        pct;
   logic        hit_any;
   logic [2:0]  hit_idx;
   logic [2:0]  key;
   logic        in_range;
   logic [31:0] neg_val;

   always_comb begin
      f = word_fin.flags;
      pct = f[NF_PCT];
      in_range = word_fin.accum <= 33'd100;
      neg_val = 32'd0 - word_fin.accum[31:0];
      set_nxt = set_cur;
      have_nxt = have_cur;
      status = ST_BAD_KEY;
      key = 3'd5;
      for (int k = 0; k < 5; k++) begin
         if (word_fin.key_match[k]) key = 3'(k);
      end
      hit_any = 1'b0;
      hit_idx = 3'd0;
      if (word_fin.phase != PH_VALUE || word_fin.key_length == 6'd0 ||
          word_fin.value_length == 6'd0 || word_fin.key_length > 6'(KEY_MAX)) begin
         status = ST_BAD_KEY;
      end else begin
         unique case (key)
            3'd0: begin
               for (int k = 4; k >= 0; k--) begin
                  if (word_fin.word_match[k] && word_fin.value_length == kw_len(k)) begin
                     hit_any = 1'b1;
                     hit_idx = 3'(k);
                  end
               end
               if (hit_any) begin
                  set_nxt.align = hit_idx;
                  status = have_cur[0] ? ST_ALIGN + 4'd1 : ST_OK;
                  have_nxt[0] = 1'b1;
               end else begin
                  status = ST_ALIGN;
               end
            end
            3'd1: begin
               if (f[NF_BAD] || f[NF_MINUS_LATE] || f[NF_PCT_LATE] || !f[NF_DIGIT] ||
                   (pct && f[NF_MINUS_FIRST]) || (pct && !in_range)) begin
                  status = ST_LINE;
               end else begin
                  if (f[NF_MINUS_FIRST]) set_nxt.line_raw = neg_val;
                  else if (word_fin.accum > 33'h07fffffff) set_nxt.line_raw = 32'h7fffffff;
                  else set_nxt.line_raw = word_fin.accum[31:0];
                  set_nxt.line_auto = 1'b0;
                  set_nxt.snap = !pct;
                  status = have_cur[1] ? ST_LINE + 4'd1 : ST_OK;
                  have_nxt[1] = 1'b1;
               end
            end
            3'd2, 3'd3: begin
               if (f[NF_BAD] || f[NF_MINUS_FIRST] || f[NF_MINUS_LATE] || f[NF_PCT_LATE] ||
                   !f[NF_DIGIT] || !pct || !in_range) begin
                  status = (key == 3'd2) ? ST_POSITION : ST_SIZE;
               end else if (key == 3'd2) begin
                  set_nxt.position = word_fin.accum[6:0];
                  status = have_cur[2] ? ST_POSITION + 4'd1 : ST_OK;
                  have_nxt[2] = 1'b1;
               end else begin
                  set_nxt.size = word_fin.accum[6:0];
                  status = have_cur[3] ? ST_SIZE + 4'd1 : ST_OK;
                  have_nxt[3] = 1'b1;
               end
            end
            3'd4: begin
               if (word_fin.word_match[5] && word_fin.value_length == kw_len(5)) begin
                  set_nxt.vertical = 2'd1;
                  hit_any = 1'b1;
               end else if (word_fin.word_match[6] && word_fin.value_length == kw_len(6)) begin
                  set_nxt.vertical = 2'd2;
                  hit_any = 1'b1;
               end
               if (hit_any) begin
                  status = have_cur[4] ? ST_VERTICAL + 4'd1 : ST_OK;
                  have_nxt[4] = 1'b1;
               end else begin
                  status = ST_VERTICAL;
               end
            end
            default: status = ST_BAD_KEY;
         endcase
      end
   end

endmodule

// ===== hdl/cue_settings_parser.sv =====
// channel  | valid / stall          | payload
// req      | req_valid / req_stall  | req_op, req_char_byte, req_line_end
// rsp      | rsp_valid / rsp_stall  | rsp_status .. rsp_last_word
// One byte per cycle while req_stall is low; a word's status is registered in the cycle
// its end byte is accepted and shown on the next cycle. Byte scan and word check are one
// combinational pass between the parse-state registers and the result register.
// Reset is synchronous and restores cue defaults. req_stall is high while a
// result is held and stalled, whether or not the next byte would produce one.
module cue_settings_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_char_byte,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [2:0]  rsp_align_mode,
   output logic signed [31:0] rsp_line_number,
   output logic        rsp_line_is_auto,
   output logic        rsp_snap_lines,
   output logic [6:0]  rsp_text_position,
   output logic [6:0]  rsp_box_size,
   output logic [1:0]  rsp_writing_dir,
   output logic        rsp_last_word
);
   import csp_pkg::*;

   word_type     word_ff, word_in, word_scan;
   settings_type set_ff, set_in, set_judge;
   logic [4:0]   have_ff, have_in, have_judge;
   logic         done_ff, done_in;
   logic [3:0]   judge_status;
   logic         rvalid_ff, rvalid_in;
   logic [3:0]   rstat_ff;
   settings_type rset_ff;
   logic         rlast_ff;
   logic         take, emit, last, is_nl, is_sp, in_word, out_free;

   csp_scan u_scan (.word_cur(word_ff), .char_byte(req_char_byte), .word_nxt(word_scan));

   csp_judge u_judge (
      .word_fin(is_nl || is_sp ? word_ff : word_scan), .set_cur(set_ff),
      .have_cur(have_ff), .set_nxt(set_judge), .have_nxt(have_judge),
      .status(judge_status));

   assign out_free = !rvalid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign take = req_valid && out_free;
   assign is_nl = req_char_byte == 8'h0d || req_char_byte == 8'h0a;
   assign is_sp = req_char_byte == 8'h20 || req_char_byte == 8'h09;
   assign in_word = word_ff.phase != PH_SKIP;

   always_comb begin
      word_in = word_ff;
      set_in = set_ff;
      have_in = have_ff;
      done_in = done_ff;
      emit = 1'b0;
      last = 1'b0;
      if (take) begin
         if (req_op) begin
            word_in = WORD_CLEAR;
            set_in = SETTINGS_DEFAULT;
            have_in = 5'd0;
            done_in = 1'b0;
         end else if (done_ff) begin
            if (req_line_end) begin
               done_in = 1'b0;
               word_in = WORD_CLEAR;
            end
         end else if (is_nl) begin
            emit = in_word;
            last = 1'b1;
            word_in = WORD_CLEAR;
            done_in = !req_line_end;
         end else if (is_sp) begin
            emit = in_word;
            last = req_line_end;
            word_in = WORD_CLEAR;
         end else if (req_line_end) begin
            emit = 1'b1;
            last = 1'b1;
            word_in = WORD_CLEAR;
         end else begin
            word_in = word_scan;
         end
         if (emit) begin
            set_in = set_judge;
            have_in = have_judge;
         end
      end
      rvalid_in = emit || (rvalid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= WORD_CLEAR;
         set_ff <= SETTINGS_DEFAULT;
         have_ff <= 5'd0;
         done_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         word_ff <= word_in;
         set_ff <= set_in;
         have_ff <= have_in;
         done_ff <= done_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rstat_ff <= judge_status;
         rset_ff <= set_in;
         rlast_ff <= last;
      end
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_status = rstat_ff;
   assign rsp_align_mode = rset_ff.align;
   assign rsp_line_number = rset_ff.line_auto ? 32'sd0 : signed'(rset_ff.line_raw);
   assign rsp_line_is_auto = rset_ff.line_auto;
   assign rsp_snap_lines = rset_ff.snap;
   assign rsp_text_position = rset_ff.position;
   assign rsp_box_size = rset_ff.size;
   assign rsp_writing_dir = rset_ff.vertical;
   assign rsp_last_word = rlast_ff;

endmodule

// ===== sim/cue_settings_parser_test.sv =====
module cue_settings_parser_test;
   import csp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic [7:0] req_char_byte = 8'd0;
   logic req_line_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_status;
   logic [2:0] rsp_align_mode;
   logic signed [31:0] rsp_line_number;
   logic rsp_line_is_auto;
   logic rsp_snap_lines;
   logic [6:0] rsp_text_position;
   logic [6:0] rsp_box_size;
   logic [1:0] rsp_writing_dir;
   logic rsp_last_word;

   cue_settings_parser DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_CUE = 1'b1;

   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  align;
      logic [31:0] line;
      logic        line_auto;
      logic        snap;
      logic [6:0]  position;
      logic [6:0]  size;
      logic [1:0]  vertical;
      logic        last;
   } status_beat_type;

   status_beat_type status_queue[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // predictor state
   phase_type   p_phase;
   int          p_key_len;
   logic [4:0]  p_key_match;
   int          p_val_len;
   logic [6:0]  p_word_match;
   logic [5:0]  p_flags;
   longint      p_accum;
   logic [4:0]  p_have;
   settings_type p_set;
   logic        p_line_done;

   function automatic string key_name(int k);
      string t[5] = '{"align", "line", "position", "size", "vertical"};
      return t[k];
   endfunction

   function automatic string kw_name(int k);
      string t[7] = '{"start", "middle", "end", "left", "right", "lr", "rl"};
      return t[k];
   endfunction

   function automatic void clear_word();
      p_phase = PH_SKIP;
      p_key_len = 0;
      p_key_match = 5'h1f;
      p_val_len = 0;
      p_word_match = 7'h7f;
      p_flags = '0;
      p_accum = 0;
   endfunction

   function automatic void restore_cue();
      clear_word();
      p_have = '0;
      p_set = SETTINGS_DEFAULT;
      p_line_done = 1'b0;
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      string s;
      if (p_phase == PH_SKIP) p_phase = PH_KEY;
      if (p_phase == PH_KEY) begin
         if (c == ":") begin
            for (int k = 0; k < 5; k++)
               if (key_name(k).len() != p_key_len) p_key_match[k] = 1'b0;
            p_phase = PH_VALUE;
            return;
         end
         for (int k = 0; k < 5; k++) begin
            s = key_name(k);
            if (p_key_len >= s.len() || s[p_key_len] != c) p_key_match[k] = 1'b0;
         end
         if (p_key_len < 63) p_key_len++;
         return;
      end
      for (int k = 0; k < 7; k++) begin
         s = kw_name(k);
         if (p_val_len >= s.len() || s[p_val_len] != c) p_word_match[k] = 1'b0;
      end
      if (p_flags[NF_PCT]) p_flags[NF_PCT_LATE] = 1'b1;
      if (c >= "0" && c <= "9") begin
         p_flags[NF_DIGIT] = 1'b1;
         p_accum = p_accum * 10 + (c - "0");
         if (p_accum > 64'h80000000) p_accum = 64'h80000000;
      end else if (c == "-") begin
         if (p_val_len == 0) p_flags[NF_MINUS_FIRST] = 1'b1;
         else p_flags[NF_MINUS_LATE] = 1'b1;
      end else if (c == "%") begin
         p_flags[NF_PCT] = 1'b1;
      end else begin
         p_flags[NF_BAD] = 1'b1;
      end
      if (p_val_len < 63) p_val_len++;
   endfunction

   function automatic bit kw_hit(int k);
      return p_word_match[k] && p_val_len == kw_name(k).len();
   endfunction

   function automatic logic [3:0] mark_key(int b, logic [3:0] base);
      if (p_have[b]) return base + 4'd1;
      p_have[b] = 1'b1;
      return ST_OK;
   endfunction

   function automatic logic [3:0] judge_word();
      int key = 5;
      logic [5:0] f = p_flags;
      if (p_phase != PH_VALUE || p_key_len == 0 || p_val_len == 0 || p_key_len > KEY_MAX)
         return ST_BAD_KEY;
      for (int k = 0; k < 5; k++)
         if (p_key_match[k]) key = k;
      case (key)
         0: begin
            for (int k = 0; k < 5; k++)
               if (kw_hit(k)) begin
                  p_set.align = 3'(k);
                  return mark_key(0, ST_ALIGN);
               end
            return ST_ALIGN;
         end
         1: begin
            if (f[NF_BAD] || f[NF_MINUS_LATE] || f[NF_PCT_LATE] || !f[NF_DIGIT] ||
                (f[NF_PCT] && f[NF_MINUS_FIRST]))
               return ST_LINE;
            if (f[NF_PCT] && p_accum > 100) return ST_LINE;
            if (f[NF_MINUS_FIRST]) p_set.line_raw = 32'(-p_accum);
            else p_set.line_raw = (p_accum > 64'h7fffffff) ? 32'h7fffffff : 32'(p_accum);
            p_set.line_auto = 1'b0;
            p_set.snap = !f[NF_PCT];
            return mark_key(1, ST_LINE);
         end
         2, 3: begin
            if (f[NF_BAD] || f[NF_MINUS_FIRST] || f[NF_MINUS_LATE] || f[NF_PCT_LATE] ||
                !f[NF_DIGIT] || !f[NF_PCT] || p_accum > 100)
               return key == 2 ? ST_POSITION : ST_SIZE;
            if (key == 2) begin
               p_set.position = 7'(p_accum);
               return mark_key(2, ST_POSITION);
            end
            p_set.size = 7'(p_accum);
            return mark_key(3, ST_SIZE);
         end
         4: begin
            for (int k = 5; k < 7; k++)
               if (kw_hit(k)) begin
                  p_set.vertical = 2'(k - 4);
                  return mark_key(4, ST_VERTICAL);
               end
            return ST_VERTICAL;
         end
         default: return ST_BAD_KEY;
      endcase
   endfunction

   function automatic void report_word(bit last);
      status_beat_type e;
      e.status = judge_word();
      e.align = p_set.align;
      e.line = p_set.line_auto ? 32'd0 : p_set.line_raw;
      e.line_auto = p_set.line_auto;
      e.snap = p_set.snap;
      e.position = p_set.position;
      e.size = p_set.size;
      e.vertical = p_set.vertical;
      e.last = last;
      status_queue.push_back(e);
      clear_word();
   endfunction

   function automatic void predict_byte(logic op, logic [7:0] c, logic le);
      bit in_word = (p_phase == PH_KEY || p_phase == PH_VALUE);
      if (op == OP_CUE) begin
         restore_cue();
         return;
      end
      if (p_line_done) begin
         if (le) begin
            p_line_done = 1'b0;
            clear_word();
         end
         return;
      end
      if (c == 8'h0d || c == 8'h0a) begin
         if (in_word) report_word(1'b1);
         clear_word();
         if (!le) p_line_done = 1'b1;
         return;
      end
      if (c == " " || c == 8'h09) begin
         if (in_word) report_word(le);
         clear_word();
         return;
      end
      scan_byte(c);
      if (le) report_word(1'b1);
   endfunction

   task automatic send_beat(logic op, logic [7:0] c, logic le);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_char_byte <= c;
      req_line_end <= le;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(op, c, le);
   endtask

   task automatic send_line(string s);
      for (int i = 0; i < s.len(); i++)
         send_beat(OP_CHAR, s[i], i == s.len() - 1);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            status_beat_type got, e;
            got = '{rsp_status, rsp_align_mode, rsp_line_number, rsp_line_is_auto,
                    rsp_snap_lines, rsp_text_position, rsp_box_size, rsp_writing_dir,
                    rsp_last_word};
            if (status_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat %h", got);
            end else begin
               e = status_queue.pop_front();
               if (got !== e) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
               end
            end
         end
      end
   end

   task automatic test_directed();
      send_line("align:start");
      send_line("align:end line:-5 position:0% size:100% vertical:lr");
      send_line("align:left align:right vertical:rl line:100% line:101% size:101%");
      send_line("line:99999999999 line:-99999999999 position:5-% line:-3% x:1 :a b: nocolon");
      send_line("line:1:2 aligned:end \tsize:50%%  position:%5");
      send_beat(OP_CHAR, 8'h00, 1'b0);
      send_beat(OP_CHAR, 8'hff, 1'b0);
      send_beat(OP_CHAR, 8'h0d, 1'b0);
      send_beat(OP_CHAR, "z", 1'b1);
      send_line("size:1%\n");
      send_line("abcdefghijklmnopqrstuvwxyz0123456789abcdefghijklmnopqrstuvwxyz:v ");
      send_beat(OP_CUE, 8'hff, 1'b1);
      send_line("align:middle\t");
   endtask

   function automatic string rand_value();
      string v;
      int n;
      case ($urandom_range(6))
         0: return kw_name($urandom_range(6));
         1: return $sformatf("%0d%%", $urandom_range(120));
         2: return $sformatf("-%0d", $urandom);
         3: return $sformatf("%0d", $urandom_range(40));
         default: begin
            v = "";
            n = $urandom_range(4);
            for (int i = 0; i < n; i++)
               case ($urandom_range(3))
                  0: v = {v, "-"};
                  1: v = {v, "%"};
                  2: v = {v, string'(8'($urandom_range(255)))};
                  default: v = {v, string'(8'("0" + $urandom_range(9)))};
               endcase
            return v;
         end
      endcase
   endfunction

   task automatic test_random(int count);
      string s;
      logic [7:0] c;
      int sent = 0;
      while (sent < count) begin
         if ($urandom_range(19) == 0) begin
            send_beat(OP_CUE, 8'($urandom), 1'($urandom));
            sent++;
         end else if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(5))
                  0: c = 8'h0d;
                  1: c = 8'h0a;
                  2: c = " ";
                  3: c = 8'h09;
                  default: c = 8'($urandom);
               endcase
               send_beat(OP_CHAR, c, $urandom_range(3) == 0);
               sent++;
            end
         end else begin
            s = "";
            repeat ($urandom_range(1, 3)) begin
               s = {s, ($urandom_range(7) == 0) ? "size" : key_name($urandom_range(4)),
                    ":", rand_value(), ($urandom_range(3) == 0) ? "\t" : " "};
            end
            if ($urandom_range(1)) s = s.substr(0, s.len() - 2);
            if (s.len() == 0) s = " ";
            send_line(s);
            sent += s.len();
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   initial begin
      restore_cue();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      send_idle_pct = 7;
      recv_idle_pct = 71;
      test_random(500);
      drain();
      send_idle_pct = 71;
      recv_idle_pct = 7;
      test_random(500);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(500);
      drain();
      if (errors == 0)
         $display("cue_settings_parser test passed");
      else
         $display("cue_settings_parser test failed");
      $finish;
   end

   initial begin
      #400000;
      $display("cue_settings_parser test failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/csp_pkg.sv
hdl/csp_scan.sv
hdl/csp_judge.sv
hdl/cue_settings_parser.sv
sim/cue_settings_parser_test.sv
